// File: rtl/core/mmips_pkg.sv
package mmips_pkg;

   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = 3;

   localparam logic REQ_EXEC    = 1'b0;
   localparam logic REQ_PRELOAD = 1'b1;

   typedef enum logic [3:0] {
      OPC_RTYPE = 4'd0,
      OPC_JUMP  = 4'd2,
      OPC_ADDI  = 4'd4,
      OPC_BEQ   = 4'd8,
      OPC_LW    = 4'd11,
      OPC_SW    = 4'd15
   } opcode_type;

   typedef enum logic [2:0] {
      FN_ADD = 3'd0,
      FN_SUB = 3'd1,
      FN_AND = 3'd2,
      FN_OR  = 3'd3
   } funct_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_OPCODE = 3'd1,
      ERR_FUNCT  = 3'd2,
      ERR_LOAD   = 3'd3,
      ERR_STORE  = 3'd4
   } error_type;

   // first member sits in the top bits
   typedef struct packed {
      error_type            error_code;
      logic                 overflow;
      logic                 zero;
      logic [7:0]           mem_address;
      logic                 mem_written;
      logic [7:0]           reg_value;
      logic [REG_IDX_W-1:0] reg_index;
      logic                 reg_written;
      logic [7:0]           next_pc;
   } rsp_type;

   localparam int RSP_W      = $bits(rsp_type);
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

endpackage

// File: rtl/core/mini_mips_8bit_instruction_step_top.sv
// Mini-MIPS 8-bit instruction step.
// Request channel (req_): one transaction per instruction or per data memory
// preload. req_tuser selects execute (0) or preload (1). The instruction word
// must be the one fetched at the next_pc of the previous result.
// Response channel (rsp_): one transaction per request, in order, carrying
// next PC, register and memory write reports, zero/overflow flags and error.
// Pipeline: a request accepted into the input register moves on to the result
// register, which drives rsp_. Throughput: one transaction per cycle while
// rsp_tready is high; the register file is read at acceptance from two
// one-read-port RAMs and the data memory is read or written once per item
// from the input stage, with forwarding of register writes still in flight.
// Reset: program counter, zero flag, register file and data memory read as
// zero; memories are cleared through per-entry valid bits, so no sweep.
// Stall: while rsp_tready is low the result register holds; the input stage
// still takes one more transaction if it is empty and then drops req_tready.
module mini_mips_8bit_instruction_step_top #(
   parameter int DATA_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [15:0] instr_word, [23:16] load_address, [31:24] load_value
   input  logic [31:0] req_tdata,
   // [0] req_type
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [7:0] next_pc, [8] reg_written, [11:9] reg_index, [19:12] reg_value,
   // [20] mem_written, [28:21] mem_address, [29] zero, [30] overflow,
   // [33:31] error_code, upper bits zero
   output logic [mmips_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int DM_AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam logic [8:0] DM_LIMIT = 9'(DATA_DEPTH);
   localparam int RI = mmips_pkg::REG_IDX_W;

   // handshake
   logic req_accept;
   logic s1_ready, s1_leave, s2_ready, s2_leave;

   // input stage
   logic       s1_valid_ff;
   logic       s1_kind_ff;
   logic [15:0] s1_word_ff;
   logic [7:0] s1_laddr_ff;
   logic [7:0] s1_lval_ff;

   // architectural state
   logic [7:0] pc_ff, pc_in;
   logic       zf_ff, zf_in;
   logic [mmips_pkg::REG_COUNT-1:0] rf_valid_ff;
   logic [DATA_DEPTH-1:0]           dm_valid_ff;

   // register file read and forwarding
   logic [7:0]    rf_a_rd, rf_b_rd;
   logic          rf_a_vld_ff, rf_b_vld_ff;
   logic          byp_vld_ff;
   logic [RI-1:0] byp_idx_ff;
   logic [7:0]    byp_val_ff;
   logic [7:0]    op_a, op_b;
   logic          rf_we;
   logic [7:0]    rf_wdata;

   // datapath
   logic [RI-1:0] rs, rt, rd;
   logic [8:0] a9, b9, imm9, sum_ab, diff_ab, sum_ai, alu_r;
   logic       alu_ok;
   logic       dm_we, dm_re;
   logic [DM_AW-1:0] dm_addr;
   logic [7:0] dm_wdata, dm_rd;
   logic       dm_rvld_ff;
   logic       is_lw;
   mmips_pkg::rsp_type res, s2_rsp_ff, rsp_out;
   logic       s2_valid_ff, s2_lw_ff;

   assign s2_ready   = !s2_valid_ff || rsp_tready;
   assign s2_leave   = s2_valid_ff && rsp_tready;
   assign s1_leave   = s1_valid_ff && s2_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_accept = req_tvalid && s1_ready;

   mmips_ram #(.WIDTH(8), .DEPTH(mmips_pkg::REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (s2_rsp_ff.reg_index),
      .wr_data (rf_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[11:9]),
      .rd_data (rf_a_rd)
   );

   mmips_ram #(.WIDTH(8), .DEPTH(mmips_pkg::REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (s2_rsp_ff.reg_index),
      .wr_data (rf_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[8:6]),
      .rd_data (rf_b_rd)
   );

   mmips_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_addr),
      .wr_data (dm_wdata),
      .rd_en   (dm_re),
      .rd_addr (dm_addr),
      .rd_data (dm_rd)
   );

   // result stage value, load data comes from the memory read register
   always_comb begin
      rsp_out = s2_rsp_ff;
      if (s2_lw_ff) begin
         rsp_out.reg_value = dm_rvld_ff ? dm_rd : 8'd0;
      end
   end

   assign rf_we      = s2_leave && s2_rsp_ff.reg_written;
   assign rf_wdata   = rsp_out.reg_value;
   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {{(mmips_pkg::RSP_DATA_W - mmips_pkg::RSP_W){1'b0}}, rsp_out};

   assign rs = s1_word_ff[11:9];
   assign rt = s1_word_ff[8:6];
   assign rd = s1_word_ff[5:3];

   // newest first: pending result, write missed by the RAM read, RAM data
   always_comb begin
      if (s2_valid_ff && s2_rsp_ff.reg_written && s2_rsp_ff.reg_index == rs) begin
         op_a = rsp_out.reg_value;
      end else if (byp_vld_ff && byp_idx_ff == rs) begin
         op_a = byp_val_ff;
      end else begin
         op_a = rf_a_vld_ff ? rf_a_rd : 8'd0;
      end
      if (s2_valid_ff && s2_rsp_ff.reg_written && s2_rsp_ff.reg_index == rt) begin
         op_b = rsp_out.reg_value;
      end else if (byp_vld_ff && byp_idx_ff == rt) begin
         op_b = byp_val_ff;
      end else begin
         op_b = rf_b_vld_ff ? rf_b_rd : 8'd0;
      end
   end

   assign a9      = {op_a[7], op_a};
   assign b9      = {op_b[7], op_b};
   assign imm9    = {{3{s1_word_ff[5]}}, s1_word_ff[5:0]};
   assign sum_ab  = a9 + b9;
   assign diff_ab = a9 - b9;
   assign sum_ai  = a9 + imm9;

   always_comb begin
      alu_ok = 1'b1;
      case (mmips_pkg::funct_type'(s1_word_ff[2:0]))
         mmips_pkg::FN_ADD: alu_r = sum_ab;
         mmips_pkg::FN_SUB: alu_r = diff_ab;
         mmips_pkg::FN_AND: alu_r = a9 & b9;
         mmips_pkg::FN_OR:  alu_r = a9 | b9;
         default: begin
            alu_r  = 9'd0;
            alu_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      res          = '0;
      res.error_code = mmips_pkg::ERR_NONE;
      pc_in        = pc_ff;
      zf_in        = zf_ff;
      dm_we        = 1'b0;
      dm_re        = 1'b0;
      dm_addr      = '0;
      dm_wdata     = s1_lval_ff;
      is_lw        = 1'b0;
      if (s1_kind_ff == mmips_pkg::REQ_PRELOAD) begin
         if ({1'b0, s1_laddr_ff} < DM_LIMIT) begin
            dm_we           = s1_leave;
            dm_addr         = s1_laddr_ff[DM_AW-1:0];
            res.mem_written = 1'b1;
            res.mem_address = s1_laddr_ff;
         end
      end else begin
         pc_in = pc_ff + 8'd1;
         case (mmips_pkg::opcode_type'(s1_word_ff[15:12]))
            mmips_pkg::OPC_RTYPE: begin
               res.reg_written = 1'b1;
               res.reg_index   = rd;
               res.reg_value   = alu_r[7:0];
               if (alu_ok) begin
                  res.overflow = alu_r[8] ^ alu_r[7];
                  zf_in        = (alu_r == 9'd0);
               end else begin
                  res.error_code = mmips_pkg::ERR_FUNCT;
               end
            end
            mmips_pkg::OPC_JUMP: begin
               pc_in = {1'b0, s1_word_ff[6:0]};
            end
            mmips_pkg::OPC_ADDI: begin
               res.reg_written = 1'b1;
               res.reg_index   = rt;
               res.reg_value   = sum_ai[7:0];
               res.overflow    = sum_ai[8] ^ sum_ai[7];
               zf_in           = (sum_ai == 9'd0);
            end
            mmips_pkg::OPC_BEQ: begin
               res.overflow = diff_ab[8] ^ diff_ab[7];
               zf_in        = (diff_ab == 9'd0);
               if (diff_ab == 9'd0) begin
                  pc_in = pc_ff + imm9[7:0];
               end
            end
            mmips_pkg::OPC_LW, mmips_pkg::OPC_SW: begin
               res.overflow = sum_ai[8] ^ sum_ai[7];
               zf_in        = (sum_ai == 9'd0);
               if (sum_ai[8] || {1'b0, sum_ai[7:0]} >= DM_LIMIT) begin
                  res.error_code = (s1_word_ff[15:12] == mmips_pkg::OPC_LW) ?
                                   mmips_pkg::ERR_LOAD : mmips_pkg::ERR_STORE;
               end else if (s1_word_ff[15:12] == mmips_pkg::OPC_LW) begin
                  dm_re           = s1_leave;
                  dm_addr         = sum_ai[DM_AW-1:0];
                  is_lw           = 1'b1;
                  res.reg_written = 1'b1;
                  res.reg_index   = rt;
                  res.mem_address = sum_ai[7:0];
               end else begin
                  dm_we           = s1_leave;
                  dm_addr         = sum_ai[DM_AW-1:0];
                  dm_wdata        = op_b;
                  res.mem_written = 1'b1;
                  res.mem_address = sum_ai[7:0];
               end
            end
            default: begin
               res.error_code = mmips_pkg::ERR_OPCODE;
            end
         endcase
      end
      res.next_pc = pc_in;
      res.zero    = zf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         byp_vld_ff  <= 1'b0;
         pc_ff       <= '0;
         zf_ff       <= 1'b0;
         rf_valid_ff <= '0;
         dm_valid_ff <= '0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (req_accept) begin
            byp_vld_ff <= rf_we;
         end
         if (s1_leave) begin
            pc_ff <= pc_in;
            zf_ff <= zf_in;
         end
         if (dm_we) begin
            dm_valid_ff[dm_addr] <= 1'b1;
         end
         if (rf_we) begin
            rf_valid_ff[s2_rsp_ff.reg_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff  <= req_tuser;
         s1_word_ff  <= req_tdata[15:0];
         s1_laddr_ff <= req_tdata[23:16];
         s1_lval_ff  <= req_tdata[31:24];
         rf_a_vld_ff <= rf_valid_ff[req_tdata[11:9]];
         rf_b_vld_ff <= rf_valid_ff[req_tdata[8:6]];
         byp_idx_ff  <= s2_rsp_ff.reg_index;
         byp_val_ff  <= rf_wdata;
      end
      if (s1_leave) begin
         s2_rsp_ff <= res;
         s2_lw_ff  <= is_lw;
      end
      if (dm_re) begin
         dm_rvld_ff <= dm_valid_ff[dm_addr];
      end
   end

   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_leave |=> $stable(pc_ff))
      else $error("program counter moved without an instruction retiring");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !(s2_rsp_ff.reg_written && s2_rsp_ff.mem_written))
      else $error("register and memory written by one transaction");

   a_err_no_reg: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_rsp_ff.reg_written |->
         (s2_rsp_ff.error_code == mmips_pkg::ERR_NONE ||
          s2_rsp_ff.error_code == mmips_pkg::ERR_FUNCT))
      else $error("register written by a faulted instruction");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff)
      else $error("input stage dropped a stalled transaction");

endmodule

// File: rtl/core/mmips_ram.sv
module mmips_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/mini_mips_8bit_instruction_step_checker.sv
module mini_mips_8bit_instruction_step_checker #(
   parameter int DATA_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [31:0]                      req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [mmips_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                               mismatches,
   output int                               outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0] cpu_pc;
   logic [7:0] cpu_regs [mmips_pkg::REG_COUNT];
   logic [7:0] cpu_mem [DATA_DEPTH];
   logic       cpu_zero;

   mmips_pkg::rsp_type predicted_steps[$];
   int                 step_count;

   function automatic mmips_pkg::rsp_type run_cpu_step(input logic kind,
                                                       input logic [31:0] d);
      mmips_pkg::rsp_type r;
      logic [15:0] w;
      logic [3:0]  opc;
      logic [2:0]  rs, rt, rd, fn;
      logic [7:0]  npc;
      int          vs, vt, imm, alu;
      bit          bad_fn;
      r = '0;
      r.error_code = mmips_pkg::ERR_NONE;
      if (kind == mmips_pkg::REQ_PRELOAD) begin
         if (int'(d[23:16]) < DATA_DEPTH) begin
            cpu_mem[d[23:16]] = d[31:24];
            r.mem_written = 1'b1;
            r.mem_address = d[23:16];
         end
      end else begin
         w   = d[15:0];
         opc = w[15:12];
         rs  = w[11:9];
         rt  = w[8:6];
         rd  = w[5:3];
         fn  = w[2:0];
         imm = $signed(w[5:0]);
         vs  = $signed(cpu_regs[rs]);
         vt  = $signed(cpu_regs[rt]);
         npc = cpu_pc + 8'd1;
         alu = 0;
         bad_fn = 1'b0;
         case (opc)
            mmips_pkg::OPC_RTYPE: begin
               case (fn)
                  mmips_pkg::FN_ADD: alu = vs + vt;
                  mmips_pkg::FN_SUB: alu = vs - vt;
                  mmips_pkg::FN_AND: alu = vs & vt;
                  mmips_pkg::FN_OR:  alu = vs | vt;
                  default:           bad_fn = 1'b1;
               endcase
               if (bad_fn) begin
                  r.error_code = mmips_pkg::ERR_FUNCT;
               end else begin
                  r.overflow = (alu > 127 || alu < -128);
                  cpu_zero = (alu == 0);
               end
               cpu_regs[rd] = alu[7:0];
               r.reg_written = 1'b1;
               r.reg_index = rd;
               r.reg_value = alu[7:0];
            end
            mmips_pkg::OPC_JUMP: npc = {1'b0, w[6:0]};
            mmips_pkg::OPC_ADDI: begin
               alu = vs + imm;
               r.overflow = (alu > 127 || alu < -128);
               cpu_zero = (alu == 0);
               cpu_regs[rt] = alu[7:0];
               r.reg_written = 1'b1;
               r.reg_index = rt;
               r.reg_value = alu[7:0];
            end
            mmips_pkg::OPC_BEQ: begin
               alu = vs - vt;
               r.overflow = (alu > 127 || alu < -128);
               cpu_zero = (alu == 0);
               if (cpu_zero)
                  npc = cpu_pc + 8'(imm);
            end
            mmips_pkg::OPC_LW, mmips_pkg::OPC_SW: begin
               alu = vs + imm;
               r.overflow = (alu > 127 || alu < -128);
               cpu_zero = (alu == 0);
               if (alu < 0 || alu >= DATA_DEPTH) begin
                  r.error_code = (opc == mmips_pkg::OPC_LW) ?
                                 mmips_pkg::ERR_LOAD : mmips_pkg::ERR_STORE;
               end else if (opc == mmips_pkg::OPC_LW) begin
                  cpu_regs[rt] = cpu_mem[alu];
                  r.reg_written = 1'b1;
                  r.reg_index = rt;
                  r.reg_value = cpu_mem[alu];
                  r.mem_address = alu[7:0];
               end else begin
                  cpu_mem[alu] = cpu_regs[rt];
                  r.mem_written = 1'b1;
                  r.mem_address = alu[7:0];
               end
            end
            default: r.error_code = mmips_pkg::ERR_OPCODE;
         endcase
         cpu_pc = npc;
      end
      r.next_pc = cpu_pc;
      r.zero = cpu_zero;
      return r;
   endfunction

   task automatic compare_field(input string name, input int want, input int seen,
                                inout bit ok);
      if (want != seen) begin
         $display("%0t: result %0d %s expected %0d, got %0d",
                  $time, step_count, name, want, seen);
         ok = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      mmips_pkg::rsp_type want, seen;
      bit                 ok;
      if (reset) begin
         cpu_pc = '0;
         cpu_zero = 1'b0;
         foreach (cpu_regs[i]) cpu_regs[i] = '0;
         foreach (cpu_mem[i]) cpu_mem[i] = '0;
         predicted_steps.delete();
         step_count = 0;
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = mmips_pkg::rsp_type'(rsp_tdata[mmips_pkg::RSP_W-1:0]);
            if (predicted_steps.size() == 0) begin
               $display("%0t: unexpected result, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = predicted_steps.pop_front();
               ok = 1'b1;
               compare_field("next_pc", want.next_pc, seen.next_pc, ok);
               compare_field("reg_written", want.reg_written, seen.reg_written, ok);
               compare_field("reg_index", want.reg_index, seen.reg_index, ok);
               compare_field("reg_value", want.reg_value, seen.reg_value, ok);
               compare_field("mem_written", want.mem_written, seen.mem_written, ok);
               compare_field("mem_address", want.mem_address, seen.mem_address, ok);
               compare_field("zero", want.zero, seen.zero, ok);
               compare_field("overflow", want.overflow, seen.overflow, ok);
               compare_field("error_code", want.error_code, seen.error_code, ok);
               compare_field("pad bits", 0,
                  int'(rsp_tdata[mmips_pkg::RSP_DATA_W-1:mmips_pkg::RSP_W]), ok);
               if (!ok)
                  mismatches++;
            end
            step_count++;
         end
         if (req_tvalid && req_tready)
            predicted_steps.push_back(run_cpu_step(req_tuser, req_tdata));
      end
      outstanding = predicted_steps.size();
   end

endmodule

// File: test/mini_mips_8bit_instruction_step_top_tb.sv
module mini_mips_8bit_instruction_step_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [2:0] FN_BAD_FIRST = 3'd4;
   localparam logic [2:0] FN_BAD_LAST  = 3'd7;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [31:0]                      req_tdata = '0;
   logic                             req_tuser = mmips_pkg::REQ_EXEC;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [mmips_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int          mismatches;
   int          outstanding;
   int          cycle_count = 0;
   int unsigned rx_phase = 0;

   mini_mips_8bit_instruction_step_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mini_mips_8bit_instruction_step_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure: free flow, coin toss, one in three, mostly ready
   always @(negedge clock) begin
      rx_phase <= rx_phase + 1;
      case (rx_phase[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(99) < 50);
         2'd2: rsp_tready <= (rx_phase % 3 == 0);
         default: rsp_tready <= ($urandom_range(99) < 85);
      endcase
   end

   function automatic logic [15:0] enc_r(input logic [2:0] fn, input logic [2:0] rs,
                                         input logic [2:0] rt, input logic [2:0] rd);
      return {mmips_pkg::OPC_RTYPE, rs, rt, rd, fn};
   endfunction

   function automatic logic [15:0] enc_i(input logic [3:0] opc, input logic [2:0] rs,
                                         input logic [2:0] rt, input logic [5:0] imm);
      return {opc, rs, rt, imm};
   endfunction

   function automatic logic [15:0] enc_j(input logic [6:0] target);
      return {mmips_pkg::OPC_JUMP, 5'($urandom), target};
   endfunction

   function automatic logic [15:0] bad_opcode_word();
      logic [3:0] opc;
      bit         valid;
      do begin
         opc = 4'($urandom);
         case (opc)
            mmips_pkg::OPC_RTYPE, mmips_pkg::OPC_JUMP, mmips_pkg::OPC_ADDI,
            mmips_pkg::OPC_BEQ, mmips_pkg::OPC_LW, mmips_pkg::OPC_SW: valid = 1'b1;
            default: valid = 1'b0;
         endcase
      end while (valid);
      return {opc, 12'($urandom)};
   endfunction

   task automatic send_item(input logic kind, input logic [31:0] data);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic exec(input logic [15:0] w);
      send_item(mmips_pkg::REQ_EXEC, {8'($urandom), 8'($urandom), w});
   endtask

   task automatic preload(input logic [7:0] addr, input logic [7:0] value);
      send_item(mmips_pkg::REQ_PRELOAD, {value, addr, 16'($urandom)});
   endtask

   task automatic go_idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic send_random_item();
      int         pick;
      logic [2:0] rs, rt, rd, fn;
      logic [5:0] imm;
      pick = $urandom_range(99);
      rs   = 3'($urandom);
      rt   = 3'($urandom);
      rd   = 3'($urandom);
      imm  = 6'($urandom);
      if ($urandom_range(7) != 0)
         fn = 3'($urandom_range(mmips_pkg::FN_ADD, mmips_pkg::FN_OR));
      else
         fn = 3'($urandom_range(FN_BAD_FIRST, FN_BAD_LAST));
      if (pick < 10)
         preload(8'($urandom), 8'($urandom));
      else if (pick < 40)
         exec(enc_r(fn, rs, rt, rd));
      else if (pick < 58)
         exec(enc_i(mmips_pkg::OPC_ADDI, rs, rt, imm));
      else if (pick < 66)
         exec(enc_i(mmips_pkg::OPC_BEQ, rs, rt, imm));
      else if (pick < 76)
         exec(enc_i(mmips_pkg::OPC_LW, rs, rt, imm));
      else if (pick < 86)
         exec(enc_i(mmips_pkg::OPC_SW, rs, rt, imm));
      else if (pick < 91)
         exec(enc_j(7'($urandom)));
      else if (pick < 96)
         exec(bad_opcode_word());
      else
         exec(16'($urandom));
   endtask

   initial begin
      int  sent;
      int  burst;
      bit  drained;
      sent = 0;
      drained = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      preload(8'd0, 8'h80);
      preload(8'd255, 8'h7F);
      preload(8'd20, 8'h7F);
      exec(enc_i(mmips_pkg::OPC_LW, 3'd0, 3'd3, 6'd0));
      exec(enc_i(mmips_pkg::OPC_LW, 3'd0, 3'd4, 6'd20));
      exec(enc_r(mmips_pkg::FN_ADD, 3'd4, 3'd4, 3'd5));
      exec(enc_r(mmips_pkg::FN_SUB, 3'd3, 3'd4, 3'd6));
      exec(enc_r(mmips_pkg::FN_AND, 3'd3, 3'd4, 3'd7));
      exec(enc_r(mmips_pkg::FN_OR, 3'd3, 3'd4, 3'd1));
      exec(enc_i(mmips_pkg::OPC_ADDI, 3'd0, 3'd2, 6'd31));
      exec(enc_i(mmips_pkg::OPC_ADDI, 3'd2, 3'd2, 6'h20));
      exec(enc_r(FN_BAD_FIRST, 3'd1, 3'd2, 3'd5));
      exec(enc_r(FN_BAD_LAST, 3'd4, 3'd3, 3'd6));
      exec(bad_opcode_word());
      exec(bad_opcode_word());
      exec(enc_i(mmips_pkg::OPC_SW, 3'd4, 3'd4, 6'd31));
      exec(enc_i(mmips_pkg::OPC_LW, 3'd4, 3'd1, 6'd31));
      exec(enc_i(mmips_pkg::OPC_SW, 3'd3, 3'd3, 6'd0));
      exec(enc_i(mmips_pkg::OPC_LW, 3'd3, 3'd2, 6'h20));
      exec(enc_j(7'h7F));
      exec(enc_i(mmips_pkg::OPC_BEQ, 3'd0, 3'd0, 6'h3F));
      exec(enc_j(7'h00));
      exec(enc_i(mmips_pkg::OPC_BEQ, 3'd0, 3'd0, 6'h3F));
      exec(enc_i(mmips_pkg::OPC_BEQ, 3'd3, 3'd4, 6'd5));

      // drain before the random traffic starts
      go_idle(1);
      wait (outstanding == 0);

      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            send_random_item();
            sent++;
         end
         if (!drained && sent >= RANDOM_ITEMS / 2) begin
            go_idle(1);
            wait (outstanding == 0);
            drained = 1'b1;
         end else if ($urandom_range(9) >= 3) begin
            go_idle($urandom_range(1, 6));
         end
      end

      go_idle(1);
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("mini_mips_8bit_instruction_step_top_tb: PASS");
      else
         $display("mini_mips_8bit_instruction_step_top_tb: FAIL");
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("mini_mips_8bit_instruction_step_top_tb: FAIL");
      $finish;
   end

endmodule
